// ----- hw/rtl/mmc_pkg.sv -----
// mmc_pkg: shared types, codes and constants of the banked memory mapper
// depends on nothing; imported by every module of the mapper
`default_nettype none

package mmc_pkg;

   localparam int WORK_RAM_DEPTH_DEF = 8192;
   localparam int CMD_QUEUE_DEPTH    = 2;
   localparam int CMD_PTR_W          = $clog2(CMD_QUEUE_DEPTH);
   localparam int CMD_CNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam int MOD_STEPS          = 8;
   localparam int MOD_STEP_W         = $clog2(MOD_STEPS);
   localparam int NUM_BANK_REGS      = 8;
   localparam int BANK_SEL_W         = $clog2(NUM_BANK_REGS);
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int COUNT_W            = 6;

   localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 6'd2;
   localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 6'd1;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_PRG_COUNT = 1'b0;
   localparam logic CSR_IDX_CHR_COUNT = 1'b1;

   // bank registers that hold program banks
   localparam logic [BANK_SEL_W-1:0] BANK_PRG_A = 3'd6;
   localparam logic [BANK_SEL_W-1:0] BANK_PRG_B = 3'd7;

   localparam logic [1:0] ACT_CPU_READ  = 2'd0;
   localparam logic [1:0] ACT_CPU_WRITE = 2'd1;
   localparam logic [1:0] ACT_CHR_READ  = 2'd2;
   localparam logic [1:0] ACT_TICK      = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RAM_RD,
      OP_RAM_WR,
      OP_PRG_RD,
      OP_CHR_RD,
      OP_BANK_SEL,
      OP_BANK_DATA,
      OP_MIRROR,
      OP_IRQ_LATCH,
      OP_IRQ_CLEAR,
      OP_IRQ_DIS,
      OP_IRQ_EN,
      OP_TICK
   } op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic        handled;
      logic        ram_access;
      logic [18:0] mapped_address;
      logic [7:0]  read_data;
      logic        irq_line;
      logic        mirror_horizontal;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] address;
      logic [7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic       start;
      logic [7:0] dividend;
      logic [8:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] remainder;
   } mod_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mmc_front.sv -----
// mmc_front: accepts requests, decodes them into commands, queues them
// depends on mmc_pkg
`default_nettype none

module mmc_front import mmc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_pop
);

   cmd_type                queue_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   cmd_type                dec;
   logic                   do_push;
   logic                   ram_window;

   assign full      = (count_ff == CMD_CNT_W'(CMD_QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign ram_window = (req_data.address[15:13] == 3'b011);

   always_comb begin
      dec.address = req_data.address;
      dec.data    = req_data.write_data;
      dec.op      = OP_NONE;
      unique case (req_data.action)
         ACT_CPU_READ: begin
            if (ram_window) dec.op = OP_RAM_RD;
            else if (req_data.address[15]) dec.op = OP_PRG_RD;
         end
         ACT_CPU_WRITE: begin
            if (ram_window) begin
               dec.op = OP_RAM_WR;
            end else if (req_data.address[15]) begin
               unique case (req_data.address[14:13])
                  2'b00: dec.op = req_data.address[0] ? OP_BANK_DATA : OP_BANK_SEL;
                  2'b01: dec.op = req_data.address[0] ? OP_NONE : OP_MIRROR;
                  2'b10: dec.op = req_data.address[0] ? OP_IRQ_CLEAR : OP_IRQ_LATCH;
                  2'b11: dec.op = req_data.address[0] ? OP_IRQ_EN : OP_IRQ_DIS;
                  default: dec.op = OP_NONE;
               endcase
            end
         end
         ACT_CHR_READ: begin
            if (req_data.address[15:13] == 3'b000) dec.op = OP_CHR_RD;
         end
         ACT_TICK: dec.op = OP_TICK;
         default: dec.op = OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !cmd_pop) count_in = count_ff + CMD_CNT_W'(1);
      else if (!do_push && cmd_pop) count_in = count_ff - CMD_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) queue_ff[wr_ptr_ff] <= dec;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mmc_mod.sv -----
// mmc_mod: restoring remainder unit, one dividend bit per cycle
// depends on mmc_pkg
`default_nettype none

module mmc_mod import mmc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type mod_req,
   output mod_rsp_type      mod_rsp
);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic [8:0]            rem_ff, rem_in;
   logic [7:0]            dvd_ff, dvd_in;
   logic [8:0]            dvs_ff, dvs_in;
   logic [9:0]            trial;

   assign trial = {rem_ff, dvd_ff[7]};
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[7:0];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      if (mod_req.start) begin
         active_in = 1'b1;
         step_in   = MOD_STEP_W'(MOD_STEPS - 1);
         rem_in    = '0;
         dvd_in    = mod_req.dividend;
         dvs_in    = mod_req.divisor;
      end else if (active_ff) begin
         // remainder stays below the divisor, so the trial fits in ten bits
         rem_in = (trial >= {1'b0, dvs_ff}) ? 9'(trial - {1'b0, dvs_ff}) : trial[8:0];
         dvd_in = {dvd_ff[6:0], 1'b0};
         step_in = step_ff - MOD_STEP_W'(1);
         if (step_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mmc_back.sv -----
// mmc_back: executes queued commands: mapper registers, window maps, work ram,
// scanline counter and the result register; depends on mmc_pkg, talks to mmc_mod by ports
`default_nettype none

module mmc_back import mmc_pkg::*; #(
   parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire cmd_type            cmd,
   output logic                    cmd_pop,
   input  wire logic [COUNT_W-1:0] prg_count,
   input  wire logic [COUNT_W-1:0] chr_count,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  wire logic               pop,
   output mod_req_type             mod_req,
   input  wire mod_rsp_type        mod_rsp
);

   localparam int RAM_AW = $clog2(WORK_RAM_DEPTH);
   localparam logic [15:0] DEPTH_X1 = 16'(WORK_RAM_DEPTH);
   localparam logic [15:0] DEPTH_X2 = 16'(2 * WORK_RAM_DEPTH);
   localparam logic [15:0] DEPTH_X4 = 16'(4 * WORK_RAM_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RAM,
      ST_MOD
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  bank_select_ff, bank_select_in;
   logic [7:0]  bank_regs_ff [NUM_BANK_REGS];
   logic [7:0]  bank_regs_in [NUM_BANK_REGS];
   logic [7:0]  irq_reload_ff, irq_reload_in;
   logic [7:0]  irq_count_ff, irq_count_in;
   logic        irq_enable_ff, irq_enable_in;
   logic        irq_pending_ff, irq_pending_in;
   logic        mirror_ff, mirror_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]  work_ram [WORK_RAM_DEPTH];
   logic [7:0]  ram_rd_ff;
   logic        ram_we, ram_re;
   logic [15:0] ram_v0, ram_v1, ram_v2, ram_v3;
   logic [RAM_AW-1:0] ram_idx;

   logic [BANK_SEL_W-1:0] sel;
   logic [8:0]  modulus;
   logic [5:0]  second_last, last_bank, prg_bank;
   logic [2:0]  chr_slot;
   logic [7:0]  chr_bank;
   logic [7:0]  tick_count;
   rsp_type     res;
   logic        res_load;

   // work ram index: (address & 0x1fff) mod depth, three conditional subtracts
   assign ram_v0  = {3'b000, cmd.address[12:0]};
   assign ram_v1  = (ram_v0 >= DEPTH_X4) ? ram_v0 - DEPTH_X4 : ram_v0;
   assign ram_v2  = (ram_v1 >= DEPTH_X2) ? ram_v1 - DEPTH_X2 : ram_v1;
   assign ram_v3  = (ram_v2 >= DEPTH_X1) ? ram_v2 - DEPTH_X1 : ram_v2;
   assign ram_idx = ram_v3[RAM_AW-1:0];

   assign sel     = bank_select_ff[BANK_SEL_W-1:0];
   assign modulus = (sel[2:1] == 2'b11) ? {2'b00, prg_count, 1'b0} : {chr_count, 3'b000};

   // fixed banks wrap within six bits
   assign second_last = {prg_count[4:0], 1'b0} + 6'd62;
   assign last_bank   = {prg_count[4:0], 1'b1} + 6'd62;

   always_comb begin
      case (cmd.address[14:13])
         2'd0:    prg_bank = bank_select_ff[6] ? second_last : bank_regs_ff[BANK_PRG_A][5:0];
         2'd1:    prg_bank = bank_regs_ff[BANK_PRG_B][5:0];
         2'd2:    prg_bank = bank_select_ff[6] ? bank_regs_ff[BANK_PRG_A][5:0] : second_last;
         default: prg_bank = last_bank;
      endcase
   end

   assign chr_slot = cmd.address[12:10] ^ {bank_select_ff[7], 2'b00};

   always_comb begin
      case (chr_slot)
         3'd0:    chr_bank = {bank_regs_ff[0][7:1], 1'b0};
         3'd1:    chr_bank = {bank_regs_ff[0][7:1], 1'b1};
         3'd2:    chr_bank = {bank_regs_ff[1][7:1], 1'b0};
         3'd3:    chr_bank = {bank_regs_ff[1][7:1], 1'b1};
         3'd4:    chr_bank = bank_regs_ff[2];
         3'd5:    chr_bank = bank_regs_ff[3];
         3'd6:    chr_bank = bank_regs_ff[4];
         default: chr_bank = bank_regs_ff[5];
      endcase
   end

   assign tick_count = (irq_count_ff == 8'd0) ? irq_reload_ff : irq_count_ff - 8'd1;

   always_comb begin
      state_in       = state_ff;
      bank_select_in = bank_select_ff;
      bank_regs_in   = bank_regs_ff;
      irq_reload_in  = irq_reload_ff;
      irq_count_in   = irq_count_ff;
      irq_enable_in  = irq_enable_ff;
      irq_pending_in = irq_pending_ff;
      mirror_in      = mirror_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !pop;
      cmd_pop        = 1'b0;
      mod_req        = '0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      res            = '0;
      res_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (!rsp_valid_ff || pop)) begin
               cmd_pop  = 1'b1;
               res_load = 1'b1;
               case (cmd.op)
                  OP_RAM_RD: begin
                     ram_re   = 1'b1;
                     res_load = 1'b0;
                     state_in = ST_RAM;
                  end
                  OP_RAM_WR: begin
                     ram_we         = 1'b1;
                     res.handled    = 1'b1;
                     res.ram_access = 1'b1;
                  end
                  OP_PRG_RD: begin
                     res.handled        = 1'b1;
                     res.mapped_address = {prg_bank, cmd.address[12:0]};
                  end
                  OP_CHR_RD: begin
                     res.handled        = 1'b1;
                     res.mapped_address = {1'b0, chr_bank, cmd.address[9:0]};
                  end
                  OP_BANK_SEL: bank_select_in = cmd.data;
                  OP_BANK_DATA: begin
                     if (modulus == '0) begin
                        bank_regs_in[sel] = cmd.data;
                     end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = cmd.data;
                        mod_req.divisor  = modulus;
                        res_load         = 1'b0;
                        state_in         = ST_MOD;
                     end
                  end
                  OP_MIRROR:    mirror_in     = cmd.data[0];
                  OP_IRQ_LATCH: irq_reload_in = cmd.data;
                  OP_IRQ_CLEAR: irq_count_in  = 8'd0;
                  OP_IRQ_DIS: begin
                     irq_enable_in  = 1'b0;
                     irq_pending_in = 1'b0;
                  end
                  OP_IRQ_EN: irq_enable_in = 1'b1;
                  OP_TICK: begin
                     irq_count_in = tick_count;
                     if (tick_count == 8'd0 && irq_enable_ff) irq_pending_in = 1'b1;
                  end
                  default: res_load = 1'b1;
               endcase
            end
         end
         ST_RAM: begin
            res_load       = 1'b1;
            res.handled    = 1'b1;
            res.ram_access = 1'b1;
            res.read_data  = ram_rd_ff;
            state_in       = ST_IDLE;
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               bank_regs_in[sel] = mod_rsp.remainder;
               res_load          = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // irq and mirroring report the state after the command
      if (res_load) begin
         rsp_in                   = res;
         rsp_in.irq_line          = irq_pending_in;
         rsp_in.mirror_horizontal = mirror_in;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bank_select_ff <= '0;
         bank_regs_ff   <= '{default: '0};
         irq_reload_ff  <= '0;
         irq_count_ff   <= '0;
         irq_enable_ff  <= 1'b0;
         irq_pending_ff <= 1'b0;
         mirror_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bank_select_ff <= bank_select_in;
         bank_regs_ff   <= bank_regs_in;
         irq_reload_ff  <= irq_reload_in;
         irq_count_ff   <= irq_count_in;
         irq_enable_ff  <= irq_enable_in;
         irq_pending_ff <= irq_pending_in;
         mirror_ff      <= mirror_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ram_we) work_ram[ram_idx] <= cmd.data;
      if (ram_re) ram_rd_ff <= work_ram[ram_idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/banked_memory_mapper_with_scanline_irq_core.sv -----
// a request is queued, executed and its result registered; a work ram read also
// passes the ram read state, and a bank data write with a nonzero bank count waits
// for the 8-step remainder unit; throughput: one request per cycle for most requests
// while results are popped; no new command is taken until such a read or write ends
// reset: synchronous, clears queues, mapper registers and irq state; counts go to
// 2 program and 1 graphics bank; work ram is not cleared and has no clearing pass
`default_nettype none

module banked_memory_mapper_with_scanline_irq_core import mmc_pkg::*; #(
   parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire req_type               req_data,
   output logic                       empty,
   input  wire logic                  pop,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [COUNT_W-1:0] prg_count_ff, prg_count_in;
   logic [COUNT_W-1:0] chr_count_ff, chr_count_in;
   logic               csr_write;
   logic               cmd_valid, cmd_pop, rsp_valid;
   cmd_type            cmd;
   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_CHR_COUNT)
                      ? {{(CSR_DATA_W - COUNT_W){1'b0}}, chr_count_ff}
                      : {{(CSR_DATA_W - COUNT_W){1'b0}}, prg_count_ff};

   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      if (csr_write) begin
         if (paddr[2] == CSR_IDX_PRG_COUNT) prg_count_in = pwdata[COUNT_W-1:0];
         else chr_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= PRG_COUNT_RESET;
         chr_count_ff <= CHR_COUNT_RESET;
      end else begin
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
      end
   end

   mmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mmc_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   mmc_back #(
      .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .prg_count (prg_count_ff),
      .chr_count (chr_count_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .pop       (pop),
      .mod_req   (mod_req),
      .mod_rsp   (mod_rsp)
   );

   assign empty = !rsp_valid;

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_no_pop_while_dividing: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |=> !cmd_pop)
      else $error("command taken while the remainder unit is busy");

   a_ram_is_handled: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.ram_access) |-> (rsp_data.handled && rsp_data.mapped_address == '0))
      else $error("work ram result without handled or with a rom address");

   a_unhandled_is_blank: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.handled) |-> (rsp_data.mapped_address == '0 &&
                                         rsp_data.read_data == '0))
      else $error("unclaimed access carries data");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the banked memory mapper core: queue-style request and result
// channels, apb-style count registers; needs mmc_pkg and the core module only
`timescale 1ns / 1ps

module testbench import mmc_pkg::*; ();

   localparam int CLK_PERIOD   = 8;
   localparam int LIMIT_CYCLES = 500000;
   localparam int RAM_WORDS    = 8192;
   localparam int PHASE_ITEMS  = 150;
   localparam int NUM_PHASES   = 6;
   localparam int HOLD_AT      = 400;
   localparam int LONG_HOLD    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   req_type req_data = '0;
   logic full;
   logic empty;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   banked_memory_mapper_with_scanline_irq_core u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // mapper state as the testbench sees it
   logic [COUNT_W-1:0] prg_count;
   logic [COUNT_W-1:0] chr_count;
   logic [7:0] bank_select;
   logic [7:0] bank_regs [NUM_BANK_REGS];
   logic [7:0] irq_reload;
   logic [7:0] irq_count;
   logic irq_enable;
   logic irq_pending;
   logic mirroring;
   logic [7:0] work_ram [RAM_WORDS];

   req_type req_pending [$];
   rsp_type rsp_expected [$];
   bit ram_seen [RAM_WORDS];
   int unsigned ram_seen_list [$];
   int items_made = 0;
   int mismatches = 0;
   int rsp_checked = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   bit no_idle = 1'b0;

   function automatic void reset_mapper_state();
      prg_count = PRG_COUNT_RESET;
      chr_count = CHR_COUNT_RESET;
      bank_select = '0;
      foreach (bank_regs[i]) bank_regs[i] = '0;
      irq_reload = '0;
      irq_count = '0;
      irq_enable = 1'b0;
      irq_pending = 1'b0;
      mirroring = 1'b0;
   endfunction

   function automatic logic [5:0] prg_bank(input logic [1:0] slot);
      logic [5:0] second_last;
      logic [5:0] last_bank;
      second_last = 6'({prg_count, 1'b0} + 7'd62);
      last_bank = second_last + 6'd1;
      case (slot)
         2'd0: return bank_select[6] ? second_last : bank_regs[BANK_PRG_A][5:0];
         2'd1: return bank_regs[BANK_PRG_B][5:0];
         2'd2: return bank_select[6] ? bank_regs[BANK_PRG_A][5:0] : second_last;
         default: return last_bank;
      endcase
   endfunction

   function automatic logic [7:0] chr_bank(input logic [2:0] slot);
      logic [2:0] s;
      s = slot ^ {bank_select[7], 2'b00};
      // lower half uses 2KB pairs, upper half single 1KB banks
      if (!s[2]) return {bank_regs[s[1]][7:1], s[0]};
      return bank_regs[s - 3'd2];
   endfunction

   function automatic void write_mapper_reg(input logic [15:0] addr, input logic [7:0] data);
      int unsigned modulus;
      if (addr < 16'hA000) begin
         if (addr[0]) begin
            modulus = (bank_select[2:0] >= BANK_PRG_A) ? int'(prg_count) * 2
                                                       : int'(chr_count) * 8;
            bank_regs[bank_select[2:0]] = (modulus != 0) ? 8'(data % modulus) : data;
         end else begin
            bank_select = data;
         end
      end else if (addr < 16'hC000) begin
         if (!addr[0]) mirroring = data[0];
      end else if (addr < 16'hE000) begin
         if (addr[0]) irq_count = '0;
         else irq_reload = data;
      end else begin
         if (addr[0]) begin
            irq_enable = 1'b1;
         end else begin
            irq_enable = 1'b0;
            irq_pending = 1'b0;
         end
      end
   endfunction

   function automatic rsp_type mapper_step(input req_type r);
      rsp_type o;
      logic in_ram;
      o = '0;
      // 0x6000-0x7FFF
      in_ram = (r.address[15:13] == 3'b011);
      case (r.action)
         ACT_CPU_READ: begin
            if (in_ram) begin
               o.handled = 1'b1;
               o.ram_access = 1'b1;
               o.read_data = work_ram[r.address[12:0]];
            end else if (r.address[15]) begin
               o.handled = 1'b1;
               o.mapped_address = {prg_bank(r.address[14:13]), r.address[12:0]};
            end
         end
         ACT_CPU_WRITE: begin
            if (in_ram) begin
               o.handled = 1'b1;
               o.ram_access = 1'b1;
               work_ram[r.address[12:0]] = r.write_data;
            end else if (r.address[15]) begin
               write_mapper_reg(r.address, r.write_data);
            end
         end
         ACT_CHR_READ: begin
            if (r.address <= 16'h1FFF) begin
               o.handled = 1'b1;
               o.mapped_address = 19'({chr_bank(r.address[12:10]), r.address[9:0]});
            end
         end
         default: begin
            if (irq_count == 0) irq_count = irq_reload;
            else irq_count = irq_count - 8'd1;
            if (irq_count == 0 && irq_enable) irq_pending = 1'b1;
         end
      endcase
      o.irq_line = irq_pending;
      o.mirror_horizontal = mirroring;
      return o;
   endfunction

   // never read a work ram entry that was not written first
   function automatic void queue_req(input logic [1:0] act, input logic [15:0] addr,
                                     input logic [7:0] data);
      req_type r;
      r.action = act;
      r.address = addr;
      r.write_data = data;
      if (addr[15:13] == 3'b011) begin
         if (act == ACT_CPU_READ && !ram_seen[addr[12:0]]) r.action = ACT_CPU_WRITE;
         if (r.action == ACT_CPU_WRITE && !ram_seen[addr[12:0]]) begin
            ram_seen[addr[12:0]] = 1'b1;
            ram_seen_list.push_back(addr[12:0]);
         end
      end
      req_pending.push_back(r);
      items_made++;
   endfunction

   function automatic void queue_rom_read();
      if ($urandom_range(0, 1))
         queue_req(ACT_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
      else
         queue_req(ACT_CHR_READ, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
   endfunction

   function automatic void queue_random_scenario();
      int n;
      int unsigned idx;
      case ($urandom_range(0, 9))
         0, 1: queue_req(ACT_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)),
                         8'($urandom));
         2: queue_req(ACT_CHR_READ, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
         3: queue_req(ACT_CPU_WRITE, {3'b011, 13'($urandom)}, 8'($urandom));
         4: begin
            idx = ram_seen_list[$urandom_range(0, ram_seen_list.size() - 1)];
            queue_req(ACT_CPU_READ, {3'b011, 13'(idx)}, 8'($urandom));
         end
         5: begin
            // select a bank register, load it, then look through the windows
            queue_req(ACT_CPU_WRITE, {3'b100, 12'($urandom), 1'b0}, 8'($urandom));
            queue_req(ACT_CPU_WRITE, {3'b100, 12'($urandom), 1'b1}, 8'($urandom));
            n = $urandom_range(1, 3);
            repeat (n) queue_rom_read();
         end
         6: begin
            // short latch, reload, enable, then count scanlines down
            queue_req(ACT_CPU_WRITE, {3'b110, 12'($urandom), 1'b0},
                      8'($urandom_range(0, 6)));
            queue_req(ACT_CPU_WRITE, {3'b110, 12'($urandom), 1'b1}, 8'($urandom));
            queue_req(ACT_CPU_WRITE, {3'b111, 12'($urandom), 1'b1}, 8'($urandom));
            n = $urandom_range(1, 9);
            repeat (n) queue_req(ACT_TICK, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 2) == 0)
               queue_req(ACT_CPU_WRITE, {3'b111, 12'($urandom), 1'b0}, 8'($urandom));
         end
         7: queue_req(ACT_CPU_WRITE, {1'b1, 15'($urandom)}, 8'($urandom));
         8: queue_req(ACT_TICK, 16'($urandom), 8'($urandom));
         default: queue_req(2'($urandom), 16'($urandom), 8'($urandom));
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_rsp(input rsp_type got);
      rsp_type want;
      if (rsp_expected.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = rsp_expected.pop_front();
      rsp_checked++;
      if (got.handled !== want.handled || got.ram_access !== want.ram_access ||
          got.mapped_address !== want.mapped_address || got.read_data !== want.read_data ||
          got.irq_line !== want.irq_line || got.mirror_horizontal !== want.mirror_horizontal)
      begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result %0d: want h=%b ram=%b addr=%h data=%h irq=%b mir=%b",
                     rsp_checked, want.handled, want.ram_access, want.mapped_address,
                     want.read_data, want.irq_line, want.mirror_horizontal);
            $display("result %0d: got  h=%b ram=%b addr=%h data=%h irq=%b mir=%b",
                     rsp_checked, got.handled, got.ram_access, got.mapped_address,
                     got.read_data, got.irq_line, got.mirror_horizontal);
         end
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         gap_left = 0;
      end else begin
         if (push && !full) rsp_expected.push_back(mapper_step(req_data));
         if (!push || !full) begin
            if (gap_left > 0) begin
               push <= 1'b0;
               gap_left--;
            end else if (req_pending.size() > 0) begin
               req_data <= req_pending.pop_front();
               push <= 1'b1;
               gap_left = pick_gap();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         hold_left = 0;
      end else begin
         if (pop && !empty) check_rsp(rsp_data);
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && rsp_checked >= HOLD_AT) begin
            // long back-pressure so the input side fills and stalls
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            pop <= 1'b0;
         end else begin
            hold_left = pick_gap();
            pop <= (hold_left == 0);
         end
      end
   end

   task automatic csr_write_count(input logic idx, input logic [COUNT_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == CSR_IDX_PRG_COUNT) prg_count = value;
      else chr_count = value;
   endtask

   task automatic wait_drained();
      while (req_pending.size() > 0 || push || rsp_expected.size() > 0) @(posedge clock);
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] prg_sets [NUM_PHASES];
      logic [COUNT_W-1:0] chr_sets [NUM_PHASES];
      prg_sets = '{6'd32, 6'd1, 6'd17, 6'd0, 6'd0, 6'd8};
      chr_sets = '{6'd32, 6'd0, 6'd5, 6'd3, 6'd0, 6'd16};
      reset_mapper_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset counts
      queue_req(ACT_CPU_WRITE, 16'h6000, 8'hFF);
      queue_req(ACT_CPU_WRITE, 16'h7FFF, 8'h00);
      queue_req(ACT_CPU_READ, 16'h6000, 8'h00);
      queue_req(ACT_CPU_READ, 16'h7FFF, 8'hFF);
      queue_req(ACT_CPU_READ, 16'h8000, 8'h00);
      queue_req(ACT_CPU_READ, 16'hFFFF, 8'h00);
      queue_req(ACT_CHR_READ, 16'h0000, 8'h00);
      queue_req(ACT_CHR_READ, 16'h1FFF, 8'h00);
      // program mode 1 and graphics inversion, bank data reduced
      queue_req(ACT_CPU_WRITE, 16'h8000, 8'hC7);
      queue_req(ACT_CPU_WRITE, 16'h9FFF, 8'hFF);
      queue_req(ACT_CPU_WRITE, 16'h8000, 8'hC6);
      queue_req(ACT_CPU_WRITE, 16'h8001, 8'hFF);
      queue_req(ACT_CPU_READ, 16'h8000, 8'h00);
      queue_req(ACT_CPU_READ, 16'hC123, 8'h00);
      queue_req(ACT_CPU_WRITE, 16'h8000, 8'h00);
      queue_req(ACT_CPU_WRITE, 16'h8001, 8'hFF);
      queue_req(ACT_CHR_READ, 16'h0400, 8'h00);
      queue_req(ACT_CPU_WRITE, 16'hA000, 8'h01);
      queue_req(ACT_CPU_WRITE, 16'hBFFF, 8'h00);
      // irq: latch 1, reload, enable, count down
      queue_req(ACT_CPU_WRITE, 16'hC000, 8'h01);
      queue_req(ACT_CPU_WRITE, 16'hDFFF, 8'h00);
      queue_req(ACT_CPU_WRITE, 16'hE001, 8'h00);
      repeat (3) queue_req(ACT_TICK, 16'hFFFF, 8'hFF);
      queue_req(ACT_CPU_WRITE, 16'hE000, 8'h00);
      // accesses the mapper does not claim
      queue_req(ACT_CPU_READ, 16'h5FFF, 8'h00);
      queue_req(ACT_CPU_WRITE, 16'h0000, 8'hFF);
      queue_req(ACT_CHR_READ, 16'h2000, 8'h00);
      queue_req(ACT_CHR_READ, 16'hFFFF, 8'h00);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 4) begin
            prg_sets[p] = COUNT_W'($urandom_range(1, 32));
            chr_sets[p] = COUNT_W'($urandom_range(0, 32));
         end
         csr_write_count(CSR_IDX_PRG_COUNT, prg_sets[p]);
         csr_write_count(CSR_IDX_CHR_COUNT, chr_sets[p]);
         no_idle = (p == 2);
         items_made = 0;
         while (items_made < PHASE_ITEMS) queue_random_scenario();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
